/* hw/rtl/bat_pkg.sv */
// Shared types and constants for the breakpoint address table.
`timescale 1ns / 1ps

package bat_pkg;

    // Field widths of the request and response words
    localparam int unsigned REQ_W   = 2;
    localparam int unsigned ADDR_W  = 64;
    localparam int unsigned WORD_W  = 64;
    localparam int unsigned POS_W   = 4;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned HIDX_W  = 4;
    localparam int unsigned COUNT_W = 5;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_ADD  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FIND = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DEL  = 2'd2;

    // Response status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_MISS  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd3;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic              key_load;   // capture the lookup address
        logic              idx_clr;    // scan index to zero
        logic              idx_pos;    // scan index to the delete position
        logic              idx_inc;    // advance scan index
        logic              rd_next;    // read entry at index + 1
        logic              add_wr;     // append request at the tail
        logic              mv_wr;      // write read data back at index
        logic              cnt_dec;    // drop one entry from the count
        logic              out_load;   // load the response register
        logic              out_hit;    // response carries the hit fields
        logic [STAT_W-1:0] out_status;
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic out_free;  // response register empty or draining
        logic cnt_zero;  // table empty
        logic full;      // table full
        logic pos_bad;   // delete position not below the count
        logic match;     // read address equals the lookup key
        logic last;      // index + 1 reaches the count
    } t_dp_stat;

endpackage

/* hw/rtl/bat_if.sv */
// Request and response channel interfaces of the breakpoint address table.
`timescale 1ns / 1ps

interface bat_req_if import bat_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic [ADDR_W-1:0] address;
    logic [WORD_W-1:0] saved_word;
    logic [POS_W-1:0]  position;

    modport source (output valid, req_type, address, saved_word, position, input ready);
    modport sink   (input valid, req_type, address, saved_word, position, output ready);
endinterface

interface bat_rsp_if import bat_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [STAT_W-1:0]  status;
    logic [HIDX_W-1:0]  hit_index;
    logic [WORD_W-1:0]  hit_word;
    logic [COUNT_W-1:0] entry_count;

    modport source (output valid, status, hit_index, hit_word, entry_count, input ready);
    modport sink   (input valid, status, hit_index, hit_word, entry_count, output ready);
endinterface

/* hw/rtl/bat_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module bat_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/bat_ctrl.sv */
// Request sequencer: decodes a request and steps find scans and delete moves.
`timescale 1ns / 1ps

module bat_ctrl import bat_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [REQ_W-1:0] i_req_type,
    output logic             o_ready,
    input  t_dp_stat         i_stat,
    output t_dp_cmd          o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_FIND_RD  = 5'b00010,
        S_FIND_CMP = 5'b00100,
        S_DEL_CHK  = 5'b01000,
        S_DEL_MV   = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE) && i_stat.out_free;

    // Next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && o_ready) begin
                    unique case (i_req_type)
                        REQ_ADD: begin
                            o_cmd.out_load = 1'b1;
                            if (i_stat.full) begin
                                o_cmd.out_status = STAT_FULL;
                            end else begin
                                o_cmd.add_wr     = 1'b1;
                                o_cmd.out_status = STAT_OK;
                            end
                        end
                        REQ_FIND: begin
                            o_cmd.key_load = 1'b1;
                            o_cmd.idx_clr  = 1'b1;
                            if (i_stat.cnt_zero) begin
                                o_cmd.out_load   = 1'b1;
                                o_cmd.out_status = STAT_MISS;
                            end else begin
                                n_state = S_FIND_RD;
                            end
                        end
                        REQ_DEL: begin
                            // pos_bad also covers the empty table
                            if (i_stat.pos_bad) begin
                                o_cmd.out_load   = 1'b1;
                                o_cmd.out_status = STAT_RANGE;
                            end else begin
                                o_cmd.idx_pos = 1'b1;
                                n_state       = S_DEL_CHK;
                            end
                        end
                        default: begin
                            o_cmd.out_load   = 1'b1;
                            o_cmd.out_status = STAT_RANGE;
                        end
                    endcase
                end
            end
            S_FIND_RD: begin
                n_state = S_FIND_CMP;
            end
            S_FIND_CMP: begin
                if (i_stat.match) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_hit    = 1'b1;
                    o_cmd.out_status = STAT_OK;
                    n_state          = S_IDLE;
                end else if (i_stat.last) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_status = STAT_MISS;
                    n_state          = S_IDLE;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_FIND_RD;
                end
            end
            S_DEL_CHK: begin
                if (i_stat.last) begin
                    o_cmd.cnt_dec    = 1'b1;
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_status = STAT_OK;
                    n_state          = S_IDLE;
                end else begin
                    o_cmd.rd_next = 1'b1;
                    n_state       = S_DEL_MV;
                end
            end
            S_DEL_MV: begin
                o_cmd.mv_wr   = 1'b1;
                o_cmd.idx_inc = 1'b1;
                n_state       = S_DEL_CHK;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/bat_datapath.sv */
// Table storage, scan index, entry count and response register.
`timescale 1ns / 1ps

module bat_datapath import bat_pkg::*; #(
    parameter int unsigned TABLE_DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_stat           o_stat,
    input  logic [ADDR_W-1:0]  i_address,
    input  logic [WORD_W-1:0]  i_saved_word,
    input  logic [POS_W-1:0]   i_position,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [STAT_W-1:0]  o_status,
    output logic [HIDX_W-1:0]  o_hit_index,
    output logic [WORD_W-1:0]  o_hit_word,
    output logic [COUNT_W-1:0] o_entry_count
);

    localparam int unsigned IW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW   = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;

    logic [CW-1:0]     r_cnt, n_cnt;
    logic [IW-1:0]     r_idx, n_idx;
    logic [ADDR_W-1:0] r_key;
    logic [CW-1:0]     idx_p1;
    logic [IW-1:0]     ram_raddr;
    logic [IW-1:0]     ram_waddr;
    logic              ram_we;
    logic [ADDR_W-1:0] wr_addr;
    logic [WORD_W-1:0] wr_word;
    logic [ADDR_W-1:0] rd_addr;
    logic [WORD_W-1:0] rd_word;

    logic               r_out_valid;
    logic [STAT_W-1:0]  r_status;
    logic [HIDX_W-1:0]  r_hit_index;
    logic [WORD_W-1:0]  r_hit_word;
    logic [COUNT_W-1:0] r_entry_count;

    // Address selection: appends go to the tail, moves write one slot down
    assign idx_p1    = CW'(r_idx) + CW'(1);
    assign ram_raddr = i_cmd.rd_next ? idx_p1[IW-1:0] : r_idx;
    assign ram_waddr = i_cmd.add_wr ? r_cnt[IW-1:0] : r_idx;
    assign ram_we    = i_cmd.add_wr | i_cmd.mv_wr;
    assign wr_addr   = i_cmd.add_wr ? i_address : rd_addr;
    assign wr_word   = i_cmd.add_wr ? i_saved_word : rd_word;

    bat_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (TABLE_DEPTH)
    ) u_addr_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (wr_addr),
        .i_raddr (ram_raddr),
        .o_rdata (rd_addr)
    );

    bat_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_DEPTH)
    ) u_word_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (wr_word),
        .i_raddr (ram_raddr),
        .o_rdata (rd_word)
    );

    // Status toward the controller
    assign o_stat.out_free = !r_out_valid || i_ready;
    assign o_stat.cnt_zero = (r_cnt == '0);
    assign o_stat.full     = (r_cnt == CW'(TABLE_DEPTH));
    assign o_stat.pos_bad  = (CMPW'(i_position) >= CMPW'(r_cnt));
    assign o_stat.match    = (rd_addr == r_key);
    assign o_stat.last     = (idx_p1 >= r_cnt);

    // Count and index next values
    always_comb begin
        n_cnt = r_cnt;
        if (i_cmd.add_wr) begin
            n_cnt = r_cnt + CW'(1);
        end else if (i_cmd.cnt_dec) begin
            n_cnt = r_cnt - CW'(1);
        end

        n_idx = r_idx;
        if (i_cmd.idx_clr) begin
            n_idx = '0;
        end else if (i_cmd.idx_pos) begin
            n_idx = IW'(i_position);
        end else if (i_cmd.idx_inc) begin
            n_idx = idx_p1[IW-1:0];
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Index, key and response word
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (i_cmd.key_load) begin
            r_key <= i_address;
        end
        if (i_cmd.out_load) begin
            r_status      <= i_cmd.out_status;
            r_hit_index   <= i_cmd.out_hit ? HIDX_W'(r_idx) : '0;
            r_hit_word    <= i_cmd.out_hit ? rd_word : '0;
            r_entry_count <= COUNT_W'(n_cnt);
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_hit_index   = r_hit_index;
    assign o_hit_word    = r_hit_word;
    assign o_entry_count = r_entry_count;

endmodule

/* hw/rtl/breakpoint_address_table_top.sv */
// Breakpoint address table: an ordered table of address / saved word entries.
// Requests arrive on i_req (add, find by address, delete at position) and
// every request yields one response word on o_rsp: status, hit index, hit
// word and the entry count after the request.
// Entries live in two RAMs with registered reads; a find walks the table
// from position 0, a delete copies later entries down one slot at a time.
// An add, an unused code, a delete out of range and a find on an empty table
// are answered straight from idle. A find steps a read state and a compare
// state per entry until a hit or the last entry; a delete at position p
// steps a check state and a move state per later entry.
// Each scan or move step is a RAM read followed by a compare or write. One
// request is in work at a time; i_req.ready is high when the sequencer is
// idle and the response register is empty or being taken in that cycle. A
// stalled response holds in its register and blocks new requests. Reset
// empties the table (count zero) and drops any pending response; RAM contents
// are not cleared and are never read past the count.
`timescale 1ns / 1ps

module breakpoint_address_table_top import bat_pkg::*; #(
    parameter int unsigned TABLE_DEPTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    bat_req_if.sink          i_req,
    bat_rsp_if.source        o_rsp
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Request sequencer
    bat_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_req.valid),
        .i_req_type (i_req.req_type),
        .o_ready    (i_req.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Storage and response path
    bat_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_address     (i_req.address),
        .i_saved_word  (i_req.saved_word),
        .i_position    (i_req.position),
        .o_valid       (o_rsp.valid),
        .i_ready       (o_rsp.ready),
        .o_status      (o_rsp.status),
        .o_hit_index   (o_rsp.hit_index),
        .o_hit_word    (o_rsp.hit_word),
        .o_entry_count (o_rsp.entry_count)
    );

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the breakpoint address table.
`timescale 1ns / 1ps

module tb_top;
    import bat_pkg::*;

    localparam int unsigned TABLE_DEPTH  = 16;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned DRAIN_CYCLES = 80;    // longer than the deepest scan or move
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned HOLD_AFTER   = 150;   // replies taken before the long hold
    localparam int unsigned IDLE_PCT     = 29;
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    // Operation mix of the random part
    typedef enum logic [1:0] {MIX_FILL, MIX_DRAIN, MIX_BOTH} t_mix;

    typedef struct packed {
        logic [REQ_W-1:0]  kind;
        logic [ADDR_W-1:0] address;
        logic [WORD_W-1:0] saved_word;
        logic [POS_W-1:0]  position;
    } t_bp_req;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [HIDX_W-1:0]  hit_index;
        logic [WORD_W-1:0]  hit_word;
        logic [COUNT_W-1:0] entry_count;
    } t_bp_rsp;

    logic clk;
    logic rst_n;

    bat_req_if req_bus ();
    bat_rsp_if rsp_bus ();

    breakpoint_address_table_top #(.TABLE_DEPTH(TABLE_DEPTH)) DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_bus.sink),
        .o_rsp   (rsp_bus.source)
    );

    // Requests waiting to be offered, and replies the table should give
    t_bp_req table_requests[$];
    t_bp_rsp table_replies[$];
    t_bp_req offered_req;

    // Shadow of the table contents
    logic [ADDR_W-1:0] shadow_addr [TABLE_DEPTH];
    logic [WORD_W-1:0] shadow_word [TABLE_DEPTH];
    int unsigned       shadow_count;

    // Entry count as the request stream plans it, used to aim deletes
    int unsigned       planned_count;
    logic [ADDR_W-1:0] addr_pool [16];

    bit          burst_mode;
    int unsigned error_count;
    int unsigned replies_taken;
    int unsigned hold_left;
    bit          hold_done;
    int unsigned cycle_count;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Apply one request to the shadow table and return the reply it yields
    function automatic t_bp_rsp table_reply_for(input t_bp_req r);
        t_bp_rsp     o;
        int unsigned i;
        bit          found;
        o.status    = STAT_OK;
        o.hit_index = '0;
        o.hit_word  = '0;
        found       = 1'b0;
        case (r.kind)
            REQ_ADD: begin
                if (shadow_count >= TABLE_DEPTH) begin
                    o.status = STAT_FULL;
                end else begin
                    shadow_addr[shadow_count] = r.address;
                    shadow_word[shadow_count] = r.saved_word;
                    shadow_count++;
                end
            end
            REQ_FIND: begin
                for (i = 0; i < shadow_count && !found; i++) begin
                    if (shadow_addr[i] == r.address) begin
                        found       = 1'b1;
                        o.hit_index = i[HIDX_W-1:0];
                        o.hit_word  = shadow_word[i];
                    end
                end
                if (!found) o.status = STAT_MISS;
            end
            REQ_DEL: begin
                if (r.position >= shadow_count) begin
                    o.status = STAT_RANGE;
                end else begin
                    for (i = r.position; i + 1 < shadow_count; i++) begin
                        shadow_addr[i] = shadow_addr[i + 1];
                        shadow_word[i] = shadow_word[i + 1];
                    end
                    shadow_count--;
                end
            end
            default: o.status = STAT_RANGE;
        endcase
        o.entry_count = shadow_count[COUNT_W-1:0];
        return o;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        if (error_count <= 40)
            $display("ERROR @%0t: %s got %0h expected %0h", $realtime, what, got, want);
    endtask

    task automatic queue_request(input logic [REQ_W-1:0] kind, input logic [63:0] addr,
                                 input logic [63:0] word, input logic [POS_W-1:0] pos);
        t_bp_req r;
        r.kind       = kind;
        r.address    = addr;
        r.saved_word = word;
        r.position   = pos;
        table_requests.push_back(r);
        if (kind == REQ_ADD && planned_count < TABLE_DEPTH) planned_count++;
        if (kind == REQ_DEL && pos < planned_count) planned_count--;
    endtask

    // Random requests: phases that fill, drain or mix, addresses mostly from a pool
    task automatic queue_random(input int unsigned n);
        int unsigned      k;
        int unsigned      roll;
        t_mix             mix;
        logic [REQ_W-1:0] kind;
        logic [63:0]      addr;
        logic [63:0]      word;
        logic [POS_W-1:0] pos;
        mix = t_mix'($urandom_range(2));
        for (k = 0; k < n; k++) begin
            if (k % 40 == 0) mix = t_mix'($urandom_range(2));
            roll = $urandom_range(99);
            case (mix)
                MIX_FILL:  kind = roll < 60 ? REQ_ADD : roll < 90 ? REQ_FIND :
                                  roll < 98 ? REQ_DEL : REQ_UNUSED;
                MIX_DRAIN: kind = roll < 15 ? REQ_ADD : roll < 40 ? REQ_FIND :
                                  roll < 98 ? REQ_DEL : REQ_UNUSED;
                default:   kind = roll < 35 ? REQ_ADD : roll < 70 ? REQ_FIND :
                                  roll < 98 ? REQ_DEL : REQ_UNUSED;
            endcase
            addr = $urandom_range(99) < 70 ? addr_pool[$urandom_range(15)] : rand64();
            roll = $urandom_range(99);
            word = roll < 5 ? '0 : roll < 10 ? '1 : rand64();
            pos  = POS_W'($urandom_range(15));
            if (kind == REQ_DEL && planned_count != 0 && $urandom_range(99) < 85)
                pos = POS_W'($urandom_range(planned_count - 1));
            queue_request(kind, addr, word, pos);
        end
    endtask

    // Wait until every request is taken and every reply has come back
    task automatic wait_all_replied();
        @(posedge clk);
        while (table_requests.size() != 0 || req_bus.valid || table_replies.size() != 0)
            @(posedge clk);
    endtask

    // Request driver: holds a word until taken, idles at random between words
    always @(posedge clk) begin : req_driver
        t_bp_req nxt;
        if (!rst_n) begin
            req_bus.valid <= 1'b0;
        end else begin
            if (req_bus.valid && req_bus.ready)
                table_replies.push_back(table_reply_for(offered_req));
            if (!req_bus.valid || req_bus.ready) begin
                if (table_requests.size() != 0 &&
                    (burst_mode || $urandom_range(99) >= IDLE_PCT)) begin
                    nxt = table_requests.pop_front();
                    offered_req        <= nxt;
                    req_bus.valid      <= 1'b1;
                    req_bus.req_type   <= nxt.kind;
                    req_bus.address    <= nxt.address;
                    req_bus.saved_word <= nxt.saved_word;
                    req_bus.position   <= nxt.position;
                end else begin
                    req_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Reply monitor: checks each reply word, stalls at random and once for a long stretch
    always @(posedge clk) begin : rsp_monitor
        t_bp_rsp want;
        if (!rst_n) begin
            rsp_bus.ready <= 1'b0;
        end else begin
            if (rsp_bus.valid && rsp_bus.ready) begin
                replies_taken <= replies_taken + 1;
                if (table_replies.size() == 0) begin
                    report_mismatch("reply with none pending", 64'(rsp_bus.status), '0);
                end else begin
                    want = table_replies.pop_front();
                    if (rsp_bus.status !== want.status)
                        report_mismatch("status", 64'(rsp_bus.status), 64'(want.status));
                    if (rsp_bus.hit_index !== want.hit_index)
                        report_mismatch("hit_index", 64'(rsp_bus.hit_index),
                                        64'(want.hit_index));
                    if (rsp_bus.hit_word !== want.hit_word)
                        report_mismatch("hit_word", rsp_bus.hit_word, want.hit_word);
                    if (rsp_bus.entry_count !== want.entry_count)
                        report_mismatch("entry_count", 64'(rsp_bus.entry_count),
                                        64'(want.entry_count));
                end
            end
            if (hold_left != 0) begin
                hold_left     <= hold_left - 1;
                rsp_bus.ready <= 1'b0;
            end else if (!hold_done && replies_taken >= HOLD_AFTER) begin
                hold_done     <= 1'b1;
                hold_left     <= HOLD_CYCLES;
                rsp_bus.ready <= 1'b0;
            end else begin
                rsp_bus.ready <= burst_mode || $urandom_range(99) >= IDLE_PCT;
            end
        end
    end

    // Run time limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned k;
        clk                = 1'b0;
        rst_n              = 1'b0;
        req_bus.valid      = 1'b0;
        req_bus.req_type   = REQ_ADD;
        req_bus.address    = '0;
        req_bus.saved_word = '0;
        req_bus.position   = '0;
        rsp_bus.ready      = 1'b0;
        offered_req        = '0;
        shadow_count       = 0;
        planned_count      = 0;
        burst_mode         = 1'b0;
        error_count        = 0;
        replies_taken      = 0;
        hold_left          = 0;
        hold_done          = 1'b0;
        cycle_count        = 0;
        addr_pool[0] = '0;
        addr_pool[1] = '1;
        for (k = 2; k < 16; k++) addr_pool[k] = rand64();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Empty table: find misses, delete and the unused code are out of range
        queue_request(REQ_FIND, '0, '0, '0);
        queue_request(REQ_DEL, '1, '1, '0);
        queue_request(REQ_UNUSED, rand64(), rand64(), '1);
        // Fill with extreme and duplicate addresses, then add past full
        queue_request(REQ_ADD, '0, '1, '1);
        queue_request(REQ_ADD, '1, '0, '0);
        queue_request(REQ_ADD, '0, 64'h0123_4567_89ab_cdef, '0);
        for (k = 3; k < TABLE_DEPTH - 1; k++)
            queue_request(REQ_ADD, addr_pool[k], rand64(), POS_W'($urandom_range(15)));
        queue_request(REQ_ADD, 64'h8000_0000_0000_0001, 64'hfeed_0000_0000_beef, '0);
        queue_request(REQ_ADD, rand64(), rand64(), '0);
        // Finds: first of a duplicate pair, the last slot, and a miss
        queue_request(REQ_FIND, '0, rand64(), '1);
        queue_request(REQ_FIND, 64'h8000_0000_0000_0001, '0, '0);
        queue_request(REQ_FIND, 64'h7fff_ffff_ffff_fffe, '1, '0);
        // Delete the tail, then the same slot again, then the head
        queue_request(REQ_DEL, '0, '0, 4'd15);
        queue_request(REQ_DEL, '1, '1, 4'd15);
        queue_request(REQ_DEL, rand64(), rand64(), 4'd0);
        // The remaining duplicate moved down to position 1
        queue_request(REQ_FIND, '0, '0, '0);

        queue_random(400);
        // Sender pause until the table has answered everything
        wait_all_replied();

        burst_mode = 1'b1;
        queue_random(300);
        while (table_requests.size() != 0) @(posedge clk);
        burst_mode = 1'b0;

        queue_random(350);
        wait_all_replied();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
